/* hdl/nfha_pkg.sv */
// Package for the next-fit heap allocator: constants, header type and codes.
// No dependencies.
package nfha_pkg;
    localparam int GRANULE_BYTES = 16;
    localparam int MAX_GRANULES  = 1024;
    localparam int GRAN_W  = $clog2(MAX_GRANULES);
    localparam int SIZE_W  = GRAN_W + 1;
    localparam int SHIFT_W = $clog2(GRANULE_BYTES);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [0:0] REG_ARENA_BASE     = 1'b0;
    localparam logic [0:0] REG_ARENA_GRANULES = 1'b1;

    typedef struct packed {
        logic              assigned;
        logic [SIZE_W-1:0] size;
    } header_t;
endpackage

/* hdl/next_fit_heap_allocator.sv */
// Top level of the next-fit heap allocator: block headers in one synchronous memory.
// Depends on nfha_pkg.
//
// Usage:
//  s_axis: one item per request; tdata = {block_address, request_bytes}, tuser = mode.
//  m_axis: one result item per request; tdata = {payload_address, status}, zero padded.
//  Config: cfg_we / cfg_index / cfg_data; write only while idle. Writing the arena size
//  reinitialises the arena to one free block with the rover at zero.
//  Walk: each header visited is read from memory, then checked (ST_RD, ST_CHK), and
//  each merged free neighbour is read and checked too (ST_MRD, ST_MCHK). A free block
//  that is too small is written back, and the walk goes on through ST_FCHK. The
//  time to a result grows with the number of blocks walked.
//  A free walks the chain from granule zero to find the block (ST_FRD, ST_FCHK per block).
//  One item is worked at a time; the result waits in an output register, and the
//  next walk starts only once the receiver has taken it. The input register is freed
//  when a walk starts, so one item may queue there, also while a receiver stalls.
//  Reset: arena of 1024 granules based at 0, one free block, rover zero.
module next_fit_heap_allocator
    import nfha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_bytes[13:0], block_address[45:14]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[0], payload_address[32:1]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_RD    = 9'b000000100,
        ST_CHK   = 9'b000001000,
        ST_MRD   = 9'b000010000,
        ST_MCHK  = 9'b000100000,
        ST_FRD   = 9'b001000000,
        ST_FCHK  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    header_t mem [MAX_GRANULES];
    header_t rd_data_reg;
    logic [GRAN_W-1:0] rd_addr;
    logic rd_en;
    logic we;
    logic [GRAN_W-1:0] wr_addr;
    header_t wr_data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    state_t state_reg, state_next;
    logic [31:0] base_reg, base_next;
    logic [SIZE_W-1:0] gran_reg, gran_next;
    logic [GRAN_W-1:0] rover_reg, rover_next;
    logic [GRAN_W-1:0] cur_reg, cur_next;
    logic [GRAN_W-1:0] start_reg, start_next;
    logic wrapped_reg, wrapped_next;
    logic [SIZE_W-1:0] csize_reg, csize_next;
    logic [SIZE_W-1:0] nx_reg, nx_next;
    logic [14:0] need_reg, need_next;
    logic mode_reg, mode_next;
    logic [GRAN_W-1:0] g_reg, g_next;
    logic init_reg, init_next;
    logic out_valid_reg, out_valid_next;
    logic out_status_reg, out_status_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic in_valid_reg, in_valid_next;
    logic [47:0] in_data_reg, in_data_next;
    logic in_mode_reg, in_mode_next;

    logic [SIZE_W-1:0] sum_nx;
    logic [SIZE_W:0] nx_wide;
    logic [31:0] off;
    logic [31:0] gfull;
    logic [10:0] cfg_g;

    assign s_axis_tready = !in_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_addr_reg, out_status_reg};

    always_comb begin
        cfg_g = cfg_data[10:0];
        if (cfg_g < 11'd2) cfg_g = 11'd2;
        if (cfg_g > 11'(MAX_GRANULES)) cfg_g = 11'(MAX_GRANULES);
    end

    assign off   = in_data_reg[45:14] - base_reg;
    assign gfull = (off >> SHIFT_W) - 32'd1;

    always_comb begin
        state_next = state_reg;
        base_next = base_reg; gran_next = gran_reg; rover_next = rover_reg;
        cur_next = cur_reg; start_next = start_reg; wrapped_next = wrapped_reg;
        csize_next = csize_reg; nx_next = nx_reg; need_next = need_reg;
        mode_next = mode_reg; g_next = g_reg; init_next = init_reg;
        out_valid_next = out_valid_reg; out_status_next = out_status_reg;
        out_addr_next = out_addr_reg;
        in_valid_next = in_valid_reg; in_data_next = in_data_reg; in_mode_next = in_mode_reg;
        rd_en = 1'b0; rd_addr = cur_reg;
        we = 1'b0; wr_addr = cur_reg; wr_data = '0;
        sum_nx = csize_reg + rd_data_reg.size;
        nx_wide = {1'b0, cur_reg} + {1'b0, rd_data_reg.size};

        if (out_valid_reg && m_axis_tready) out_valid_next = 1'b0;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
            in_data_next = s_axis_tdata;
            in_mode_next = s_axis_tuser;
        end

        if (init_reg) begin
            we = 1'b1; wr_addr = '0;
            wr_data.assigned = 1'b0; wr_data.size = gran_reg;
            init_next = 1'b0;
        end
        if (cfg_we) begin
            if (cfg_index == REG_ARENA_BASE) begin
                base_next = cfg_data;
            end else begin
                gran_next = cfg_g;
                rover_next = '0;
                init_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid_reg && !out_valid_reg && !init_reg) begin
                    in_valid_next = 1'b0;
                    mode_next = in_mode_reg;
                    need_next = (15'(in_data_reg[13:0]) + 15'(2*GRANULE_BYTES-1)) >> SHIFT_W;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (mode_reg == MODE_ALLOC) begin
                    if (need_reg > 15'(gran_reg)) begin
                        out_status_next = 1'b1; out_addr_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        cur_next = rover_reg; start_next = rover_reg;
                        wrapped_next = 1'b0;
                        rd_en = 1'b1; rd_addr = rover_reg;
                        state_next = ST_RD;
                    end
                end else begin
                    out_status_next = 1'b0; out_addr_next = '0;
                    g_next = gfull[GRAN_W-1:0];
                    if (off < 32'(GRANULE_BYTES) || off[SHIFT_W-1:0] != '0
                        || gfull >= 32'(gran_reg)) begin
                        state_next = ST_DONE;
                    end else begin
                        cur_next = '0; rd_en = 1'b1; rd_addr = '0;
                        state_next = ST_FRD;
                    end
                end
            end
            ST_RD: state_next = ST_CHK;
            ST_CHK: begin
                if (!rd_data_reg.assigned) begin
                    csize_next = rd_data_reg.size;
                    nx_next = SIZE_W'(nx_wide);
                    if (nx_wide < {1'b0, gran_reg}) begin
                        rd_en = 1'b1; rd_addr = nx_wide[GRAN_W-1:0];
                        state_next = ST_MRD;
                    end else begin
                        state_next = ST_MCHK;
                        nx_next = gran_reg;
                    end
                end else begin
                    if (nx_wide >= {1'b0, gran_reg}) begin
                        wrapped_next = 1'b1;
                        if (start_reg == '0) begin
                            out_status_next = 1'b1; out_addr_next = '0;
                            state_next = ST_DONE;
                        end else begin
                            cur_next = '0; rd_en = 1'b1; rd_addr = '0;
                            state_next = ST_RD;
                        end
                    end else if (wrapped_reg && nx_wide[GRAN_W-1:0] >= start_reg) begin
                        out_status_next = 1'b1; out_addr_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        cur_next = nx_wide[GRAN_W-1:0];
                        rd_en = 1'b1; rd_addr = nx_wide[GRAN_W-1:0];
                        state_next = ST_RD;
                    end
                end
            end
            ST_MRD: state_next = ST_MCHK;
            ST_MCHK: begin
                if (nx_reg < gran_reg && !rd_data_reg.assigned) begin
                    if (nx_reg[GRAN_W-1:0] == rover_reg) rover_next = cur_reg;
                    csize_next = sum_nx;
                    nx_next = SIZE_W'(cur_reg) + sum_nx;
                    if (SIZE_W'(cur_reg) + sum_nx < gran_reg) begin
                        rd_en = 1'b1; rd_addr = GRAN_W'(SIZE_W'(cur_reg) + sum_nx);
                        state_next = ST_MRD;
                    end else begin
                        nx_next = gran_reg;
                    end
                end else begin
                    we = 1'b1; wr_addr = cur_reg;
                    if (mode_reg == MODE_FREE) begin
                        wr_data.assigned = 1'b0; wr_data.size = csize_reg;
                        state_next = ST_DONE;
                    end else if (15'(csize_reg) >= need_reg) begin
                        wr_data.assigned = 1'b1; wr_data.size = SIZE_W'(need_reg);
                        out_status_next = 1'b0;
                        out_addr_next = base_reg
                            + ((32'(cur_reg) + 32'd1) << SHIFT_W);
                        state_next = ST_DONE;
                        if (15'(csize_reg) > need_reg) begin
                            state_next = ST_FRD; // write remainder next cycle
                            g_next = GRAN_W'(SIZE_W'(cur_reg) + SIZE_W'(need_reg));
                            rover_next = GRAN_W'(SIZE_W'(cur_reg) + SIZE_W'(need_reg));
                            csize_next = csize_reg - SIZE_W'(need_reg);
                        end else begin
                            rover_next = (nx_reg < gran_reg) ? nx_reg[GRAN_W-1:0] : '0;
                        end
                    end else begin
                        wr_data.assigned = 1'b0; wr_data.size = csize_reg;
                        if (nx_reg >= gran_reg) begin
                            wrapped_next = 1'b1;
                            if (start_reg == '0) begin
                                out_status_next = 1'b1; out_addr_next = '0;
                                state_next = ST_DONE;
                            end else begin
                                cur_next = '0; state_next = ST_FCHK;
                            end
                        end else if (wrapped_reg && nx_reg[GRAN_W-1:0] >= start_reg) begin
                            out_status_next = 1'b1; out_addr_next = '0;
                            state_next = ST_DONE;
                        end else begin
                            cur_next = nx_reg[GRAN_W-1:0]; state_next = ST_FCHK;
                        end
                    end
                end
            end
            ST_FRD: begin
                if (mode_reg == MODE_ALLOC) begin
                    we = 1'b1; wr_addr = g_reg;
                    wr_data.assigned = 1'b0; wr_data.size = csize_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_FCHK;
                end
            end
            ST_FCHK: begin
                if (mode_reg == MODE_ALLOC) begin
                    // read the next block after write-back of the merged block
                    rd_en = 1'b1; rd_addr = cur_reg;
                    state_next = ST_RD;
                end else if (cur_reg < g_reg) begin
                    cur_next = nx_wide[GRAN_W-1:0];
                    if (nx_wide > {1'b0, g_reg}) begin
                        state_next = ST_DONE;
                    end else begin
                        rd_en = 1'b1; rd_addr = nx_wide[GRAN_W-1:0];
                        state_next = ST_FRD;
                    end
                end else if (!rd_data_reg.assigned) begin
                    state_next = ST_DONE;
                end else begin
                    csize_next = rd_data_reg.size;
                    nx_next = SIZE_W'(nx_wide);
                    if (nx_wide < {1'b0, gran_reg}) begin
                        rd_en = 1'b1; rd_addr = nx_wide[GRAN_W-1:0];
                        state_next = ST_MRD;
                    end else begin
                        nx_next = gran_reg;
                        state_next = ST_MCHK;
                    end
                end
            end
            ST_DONE: begin
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg <= '0;
            gran_reg <= SIZE_W'(MAX_GRANULES);
            rover_reg <= '0;
            init_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg <= base_next;
            gran_reg <= gran_next;
            rover_reg <= rover_next;
            init_reg <= init_next;
            out_valid_reg <= out_valid_next;
            in_valid_reg <= in_valid_next;
        end
        cur_reg <= cur_next; start_reg <= start_next; wrapped_reg <= wrapped_next;
        csize_reg <= csize_next; nx_reg <= nx_next; need_reg <= need_next;
        mode_reg <= mode_next; g_reg <= g_next;
        out_status_reg <= out_status_next; out_addr_reg <= out_addr_next;
        in_data_reg <= in_data_next; in_mode_reg <= in_mode_next;
    end
endmodule

/* hdl/nfha_checker.sv */
// Port-level checker for the next-fit heap allocator, bound to the top level.
// Depends on nfha_pkg and next_fit_heap_allocator.
module nfha_checker
    import nfha_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
        else $error("failed item carries an address");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("padding bits not zero");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");
    a_in_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input register still ready after taking an item");
endmodule

bind next_fit_heap_allocator nfha_checker u_nfha_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
